// File: rtl/float_exp_approximation_top_macros.svh
// Assertion macros shared by the float exp approximation RTL.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef FLOAT_EXP_APPROXIMATION_TOP_MACROS_SVH
`define FLOAT_EXP_APPROXIMATION_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define FEXP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fexp assertion failed");

// next-cycle implication, disabled in reset
`define FEXP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fexp assertion failed");

`endif

// File: rtl/fexp_pkg.sv
// Types, float32 constants and the per-cell operation table of the exp pipeline.
// Depends on nothing; used by fexp_cell and float_exp_approximation_top.
package fexp_pkg;

    localparam int NUM_CELLS = 20;

    localparam logic [31:0] BOUND     = 32'h42B0C0A5;
    localparam logic [31:0] NEG_BOUND = 32'hC2B0C0A5;
    localparam logic [31:0] LOG2E     = 32'h3FB8AA3B;
    localparam logic [31:0] LN2       = 32'h3F317218;
    localparam logic [31:0] HALF      = 32'h3F000000;
    localparam logic [31:0] ONE       = 32'h3F800000;
    localparam logic [31:0] QNAN      = 32'h7FC00000;
    localparam logic [31:0] C0        = 32'h39506967;
    localparam logic [31:0] C1        = 32'h3AB743CE;
    localparam logic [31:0] C2        = 32'h3C088908;
    localparam logic [31:0] C3        = 32'h3D2AA9C1;
    localparam logic [31:0] C4        = 32'h3E2AAAAA;
    localparam logic [31:0] C5        = 32'h3F000000;
    localparam logic [8:0]  EXP_BIAS  = 9'd127;

    typedef enum logic [1:0] {
        KIND_MUL,
        KIND_ADD,
        KIND_FLOOR
    } kind_t;

    typedef enum logic [1:0] {
        ASEL_ACC,
        ASEL_Y,
        ASEL_R
    } a_sel_t;

    typedef enum logic [2:0] {
        BSEL_CONST,
        BSEL_ACC,
        BSEL_R,
        BSEL_Z,
        BSEL_SCALE
    } b_sel_t;

    typedef struct packed {
        kind_t       kind;
        a_sel_t      a_sel;
        b_sel_t      b_sel;
        logic        b_neg;
        logic [31:0] b_const;
        logic        wr_r;
        logic        wr_z;
        logic        load_c0;
    } op_t;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] r;
        logic [31:0] z;
        logic [8:0]  n;
    } ctx_t;

    typedef struct packed {
        logic [31:0] acc;
        ctx_t        ctx;
    } word_t;

    function automatic op_t op_at(input int idx);
        op_t o;
        o.kind    = KIND_MUL;
        o.a_sel   = ASEL_ACC;
        o.b_sel   = BSEL_CONST;
        o.b_neg   = 1'b0;
        o.b_const = ONE;
        o.wr_r    = 1'b0;
        o.wr_z    = 1'b0;
        o.load_c0 = 1'b0;
        case (idx)
            0: o.b_const = LOG2E;
            1: begin
                o.kind    = KIND_ADD;
                o.b_const = HALF;
            end
            2: o.kind = KIND_FLOOR;
            3: o.b_const = LN2;
            4: begin
                o.kind  = KIND_ADD;
                o.a_sel = ASEL_Y;
                o.b_sel = BSEL_ACC;
                o.b_neg = 1'b1;
                o.wr_r  = 1'b1;
            end
            5: begin
                o.a_sel   = ASEL_R;
                o.b_sel   = BSEL_R;
                o.wr_z    = 1'b1;
                o.load_c0 = 1'b1;
            end
            6, 8, 10, 12, 14: o.b_sel = BSEL_R;
            7: begin
                o.kind    = KIND_ADD;
                o.b_const = C1;
            end
            9: begin
                o.kind    = KIND_ADD;
                o.b_const = C2;
            end
            11: begin
                o.kind    = KIND_ADD;
                o.b_const = C3;
            end
            13: begin
                o.kind    = KIND_ADD;
                o.b_const = C4;
            end
            15: begin
                o.kind    = KIND_ADD;
                o.b_const = C5;
            end
            16: o.b_sel = BSEL_Z;
            17: begin
                o.kind  = KIND_ADD;
                o.b_sel = BSEL_R;
            end
            18: begin
                o.kind    = KIND_ADD;
                o.b_const = ONE;
            end
            19: o.b_sel = BSEL_SCALE;
            default: o.b_const = ONE;
        endcase
        return o;
    endfunction

endpackage

// File: rtl/float_exp_approximation_top.sv
// Structure: 20 cells, 3 register stages each, between input request and result.
// Throughput: one request per cycle while m_ready is high; a full stage holds when the stage after it is stalled.
// Each cell owns one rounded float32 operation; cell count sets the latency.
// Reset: synchronous, active-low aresetn clears all stage valid bits.
// Top level of the float exp pipeline; depends on fexp_pkg and fexp_cell.
module float_exp_approximation_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_x_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_bits
);

    logic            vld [0:fexp_pkg::NUM_CELLS];
    logic            rdy [0:fexp_pkg::NUM_CELLS];
    fexp_pkg::word_t dat [0:fexp_pkg::NUM_CELLS];
    logic            x_nan;
    logic            lt_hi;
    logic            gt_lo;
    logic [31:0]     y_hi;
    logic [31:0]     y_cl;

    // clamp; a NaN of either sign takes the upper bound
    always_comb begin
        x_nan = (&s_x_bits[30:23]) && (|s_x_bits[22:0]);
        lt_hi = !x_nan && (s_x_bits[31] || (s_x_bits[30:0] < fexp_pkg::BOUND[30:0]));
        y_hi  = lt_hi ? s_x_bits : fexp_pkg::BOUND;
        gt_lo = !y_hi[31] || (y_hi[30:0] < fexp_pkg::BOUND[30:0]);
        y_cl  = gt_lo ? y_hi : fexp_pkg::NEG_BOUND;
    end

    assign vld[0]         = s_valid;
    assign s_ready        = rdy[0];
    assign dat[0].acc     = y_cl;
    assign dat[0].ctx.y   = y_cl;
    assign dat[0].ctx.r   = 32'd0;
    assign dat[0].ctx.z   = 32'd0;
    assign dat[0].ctx.n   = 9'd0;

    genvar i;
    generate
        for (i = 0; i < fexp_pkg::NUM_CELLS; i++) begin : g_cell
            fexp_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .op_i        (fexp_pkg::op_at(i)),
                .in_valid_i  (vld[i]),
                .in_ready_o  (rdy[i]),
                .in_data_i   (dat[i]),
                .out_valid_o (vld[i+1]),
                .out_ready_i (rdy[i+1]),
                .out_data_o  (dat[i+1])
            );
        end
    endgenerate

    assign m_valid                       = vld[fexp_pkg::NUM_CELLS];
    assign rdy[fexp_pkg::NUM_CELLS]      = m_ready;
    assign m_result_bits                 = dat[fexp_pkg::NUM_CELLS].acc;

endmodule

// File: rtl/fexp_cell.sv
// One pipeline cell: a single rounded float32 multiply, add or floor step,
// three register stages (operate, normalize, round). Depends on fexp_pkg.
`include "float_exp_approximation_top_macros.svh"

module fexp_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  fexp_pkg::op_t       op_i,
    input  logic                in_valid_i,
    output logic                in_ready_o,
    input  fexp_pkg::word_t     in_data_i,
    output logic                out_valid_o,
    input  logic                out_ready_i,
    output fexp_pkg::word_t     out_data_o
);

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_bits;
        logic               sign;
        logic signed [10:0] expo;
        logic [47:0]        mant;
    } raw_t;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_bits;
        logic               sign;
        logic               zero;
        logic signed [10:0] expo;
        logic [47:0]        mant;
    } norm_t;

    function automatic raw_t mul_raw(input logic [31:0] a, input logic [31:0] b);
        raw_t        r;
        logic [8:0]  ea;
        logic [8:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic        an;
        logic        bn;
        logic        ai;
        logic        bi;
        logic        az;
        logic        bz;
        ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
        eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        an = (&a[30:23]) && (|a[22:0]);
        bn = (&b[30:23]) && (|b[22:0]);
        ai = (&a[30:23]) && !(|a[22:0]);
        bi = (&b[30:23]) && !(|b[22:0]);
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        r.sign      = a[31] ^ b[31];
        r.expo      = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 11'sd127;
        r.mant      = ma * mb;
        r.spec      = 1'b0;
        r.spec_bits = fexp_pkg::QNAN;
        if (an || bn || (ai && bz) || (bi && az)) begin
            r.spec = 1'b1;
        end else if (ai || bi) begin
            r.spec      = 1'b1;
            r.spec_bits = {r.sign, 8'hFF, 23'd0};
        end
        return r;
    endfunction

    function automatic raw_t add_raw(input logic [31:0] a, input logic [31:0] b);
        raw_t        r;
        logic [8:0]  ea;
        logic [8:0]  eb;
        logic [8:0]  ebig;
        logic [8:0]  d;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [23:0] mbig;
        logic [23:0] msml;
        logic        sbig;
        logic        ssml;
        logic [47:0] mb0;
        logic [47:0] ms0;
        logic [47:0] mss;
        logic        st;
        logic        an;
        logic        bn;
        logic        ai;
        logic        bi;
        ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
        eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        an = (&a[30:23]) && (|a[22:0]);
        bn = (&b[30:23]) && (|b[22:0]);
        ai = (&a[30:23]) && !(|a[22:0]);
        bi = (&b[30:23]) && !(|b[22:0]);
        if (eb > ea) begin
            ebig = eb;
            d    = eb - ea;
            mbig = mb;
            msml = ma;
            sbig = b[31];
            ssml = a[31];
        end else begin
            ebig = ea;
            d    = ea - eb;
            mbig = ma;
            msml = mb;
            sbig = a[31];
            ssml = b[31];
        end
        mb0 = {1'b0, mbig, 23'd0};
        ms0 = {1'b0, msml, 23'd0};
        if (d >= 9'd48) begin
            mss = {47'd0, |msml};
        end else begin
            mss = ms0 >> d[5:0];
            st  = |(ms0 & ((48'd1 << d[5:0]) - 48'd1));
            mss[0] = mss[0] | st;
        end
        if (sbig == ssml) begin
            r.mant = mb0 + mss;
            r.sign = sbig;
        end else if (mb0 >= mss) begin
            r.mant = mb0 - mss;
            r.sign = sbig;
        end else begin
            r.mant = mss - mb0;
            r.sign = ssml;
        end
        if (r.mant == 48'd0) begin
            r.sign = (a[31] == b[31]) ? a[31] : 1'b0;
        end
        r.expo      = $signed({2'b00, ebig});
        r.spec      = 1'b0;
        r.spec_bits = fexp_pkg::QNAN;
        if (an || bn || (ai && bi && (a[31] != b[31]))) begin
            r.spec = 1'b1;
        end else if (ai) begin
            r.spec      = 1'b1;
            r.spec_bits = {a[31], 8'hFF, 23'd0};
        end else if (bi) begin
            r.spec      = 1'b1;
            r.spec_bits = {b[31], 8'hFF, 23'd0};
        end
        return r;
    endfunction

    function automatic logic [9:0] floor_int(input logic [31:0] a);
        logic [23:0] mag;
        logic [7:0]  sh;
        logic [8:0]  ipart;
        logic        fracnz;
        mag = {1'b1, a[22:0]};
        if (a[30:23] < 8'd127) begin
            ipart  = 9'd0;
            fracnz = (a[30:0] != 31'd0);
        end else begin
            sh     = (a[30:23] > 8'd150) ? 8'd0 : (8'd150 - a[30:23]);
            ipart  = 9'((mag >> sh[4:0]));
            fracnz = |(mag & ((24'd1 << sh[4:0]) - 24'd1));
        end
        if (a[31]) begin
            ipart = ipart + {8'd0, fracnz};
        end
        return {a[31] && (ipart != 9'd0), ipart};
    endfunction

    function automatic logic [5:0] clz48(input logic [47:0] v);
        logic [5:0] c;
        logic       found;
        c     = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    c = c + 6'd1;
                end
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] round_pack(input norm_t v);
        logic [10:0]        sh;
        logic [47:0]        ms;
        logic               ex;
        logic [23:0]        frac;
        logic               g;
        logic               s;
        logic               inc;
        logic [24:0]        m25;
        logic signed [10:0] fld;
        logic [31:0]        res;
        sh = (v.expo > 11'sd0) ? 11'd0 : 11'(11'sd1 - v.expo);
        if (sh > 11'd48) begin
            ms = 48'd0;
            ex = |v.mant;
        end else begin
            ms = v.mant >> sh[5:0];
            ex = |(v.mant & ((48'd1 << sh[5:0]) - 48'd1));
        end
        frac = ms[47:24];
        g    = ms[23];
        s    = (|ms[22:0]) | ex;
        inc  = g & (s | frac[0]);
        m25  = {1'b0, frac} + {24'd0, inc};
        if (v.expo > 11'sd0) begin
            fld = v.expo + $signed({10'd0, m25[24]});
            if (fld >= 11'sd255) begin
                res = {v.sign, 8'hFF, 23'd0};
            end else begin
                res = {v.sign, fld[7:0], m25[22:0]};
            end
        end else begin
            res = {v.sign, 7'd0, m25[23], m25[22:0]};
        end
        if (v.spec) begin
            res = v.spec_bits;
        end else if (v.zero) begin
            res = {v.sign, 31'd0};
        end
        return res;
    endfunction

    logic            va_reg;
    logic            vb_reg;
    logic            vc_reg;
    raw_t            ra_reg;
    raw_t            ra_next;
    norm_t           nb_reg;
    norm_t           nb_next;
    fexp_pkg::word_t da_reg;
    fexp_pkg::word_t da_next;
    fexp_pkg::word_t db_reg;
    fexp_pkg::word_t dc_reg;
    fexp_pkg::word_t dc_next;
    logic            ready_a;
    logic            ready_b;
    logic            ready_c;
    logic [31:0]     a_op;
    logic [31:0]     b_op;
    logic [9:0]      fl;
    logic [5:0]      lz;
    logic [31:0]     res;

    assign ready_c     = !vc_reg || out_ready_i;
    assign ready_b     = !vb_reg || ready_c;
    assign ready_a     = !va_reg || ready_b;
    assign in_ready_o  = ready_a;
    assign out_valid_o = vc_reg;
    assign out_data_o  = dc_reg;

    // operate
    always_comb begin
        case (op_i.a_sel)
            fexp_pkg::ASEL_ACC: a_op = in_data_i.acc;
            fexp_pkg::ASEL_Y:   a_op = in_data_i.ctx.y;
            fexp_pkg::ASEL_R:   a_op = in_data_i.ctx.r;
            default:            a_op = in_data_i.acc;
        endcase
        case (op_i.b_sel)
            fexp_pkg::BSEL_CONST: b_op = op_i.b_const;
            fexp_pkg::BSEL_ACC:   b_op = in_data_i.acc;
            fexp_pkg::BSEL_R:     b_op = in_data_i.ctx.r;
            fexp_pkg::BSEL_Z:     b_op = in_data_i.ctx.z;
            fexp_pkg::BSEL_SCALE: b_op = {in_data_i.ctx.n + fexp_pkg::EXP_BIAS, 23'd0};
            default:              b_op = op_i.b_const;
        endcase
        b_op[31] = b_op[31] ^ op_i.b_neg;
        fl       = floor_int(a_op);
        da_next  = in_data_i;
        case (op_i.kind)
            fexp_pkg::KIND_MUL: ra_next = mul_raw(a_op, b_op);
            fexp_pkg::KIND_ADD: ra_next = add_raw(a_op, b_op);
            fexp_pkg::KIND_FLOOR: begin
                ra_next.spec      = 1'b0;
                ra_next.spec_bits = fexp_pkg::QNAN;
                ra_next.sign      = fl[9];
                ra_next.expo      = 11'sd135;
                ra_next.mant      = {1'b0, fl[8:0], 38'd0};
                da_next.ctx.n     = fl[9] ? (9'd0 - fl[8:0]) : fl[8:0];
            end
            default: ra_next = mul_raw(a_op, b_op);
        endcase
    end

    // normalize
    always_comb begin
        lz                = clz48(ra_reg.mant);
        nb_next.spec      = ra_reg.spec;
        nb_next.spec_bits = ra_reg.spec_bits;
        nb_next.sign      = ra_reg.sign;
        nb_next.zero      = (ra_reg.mant == 48'd0);
        nb_next.expo      = ra_reg.expo - $signed({5'd0, lz}) + 11'sd1;
        nb_next.mant      = ra_reg.mant << lz;
    end

    // round and route
    always_comb begin
        res     = round_pack(nb_reg);
        dc_next = db_reg;
        dc_next.acc = op_i.load_c0 ? fexp_pkg::C0 : res;
        if (op_i.wr_r) begin
            dc_next.ctx.r = res;
        end
        if (op_i.wr_z) begin
            dc_next.ctx.z = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                va_reg <= in_valid_i;
            end
            if (ready_b) begin
                vb_reg <= va_reg;
            end
            if (ready_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid_i) begin
            ra_reg <= ra_next;
            da_reg <= da_next;
        end
        if (ready_b && va_reg) begin
            nb_reg <= nb_next;
            db_reg <= da_reg;
        end
        if (ready_c && vb_reg) begin
            dc_reg <= dc_next;
        end
    end

    `FEXP_ASSERT_IMP(a_stall_only_when_full, !in_ready_o, va_reg)
    `FEXP_ASSERT_NXT(a_hold_valid, out_valid_o && !out_ready_i, out_valid_o)
    `FEXP_ASSERT_NXT(a_hold_data, out_valid_o && !out_ready_i, $stable(out_data_o))

endmodule

// File: test/tb_top.sv
// Self-checking testbench for float_exp_approximation_top: a directed table, then random
// float32 arguments, each checked bit for bit against a known result or an in-bench binary32 exp predictor.
// Depends on the RTL top level float_exp_approximation_top and its package only.
`timescale 1ns / 1ps

module tb_top;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_x_bits;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_result_bits;

    logic [31:0] exp_queue[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    int          hold_cnt;
    bit          stim_done;

    typedef struct {
        logic [31:0] x;
        bit          known;
        logic [31:0] result;
    } dir_row_t;

    float_exp_approximation_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_x_bits      (s_x_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_bits (m_result_bits)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic real bits_to_real(logic [31:0] b);
        int          e;
        logic [63:0] d;
        e = int'(b[30:23]);
        if (e == 255) begin
            d = {b[31], 11'h7ff, (b[22:0] != 0) ? 52'h8000000000000 : 52'h0};
        end else if (e == 0) begin
            return (b[31] ? -1.0 : 1.0) * real'(int'(b[22:0])) * (2.0 ** -149);
        end else begin
            d = {b[31], 11'(e - 127 + 1023), b[22:0], 29'h0};
        end
        return $bitstoreal(d);
    endfunction

    // round a double to binary32, nearest even, with subnormals and overflow
    function automatic logic [31:0] real_to_bits(real v);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          ee;
        int          sh;
        d = $realtobits(v);
        if (d[62:52] == 11'h7ff) begin
            if (d[51:0] != 0) return 32'h7FC00000;
            return {d[63], 8'hff, 23'h0};
        end
        if (d[62:0] == 0) return {d[63], 31'h0};
        ee   = int'(d[62:52]) - 1023;
        sig  = {11'h0, 1'b1, d[51:0]};
        sh   = (ee >= -126) ? 29 : 29 + (-126 - ee);
        if (sh >= 54) return {d[63], 31'h0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
        if (ee >= -126) begin
            if (kept[24]) begin
                kept = kept >> 1;
                ee   = ee + 1;
            end
            if (ee > 127) return {d[63], 8'hff, 23'h0};
            return {d[63], 8'(ee + 127), kept[22:0]};
        end
        return {d[63], kept[30:0]};
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        return real_to_bits(bits_to_real(a) * bits_to_real(b));
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        return real_to_bits(bits_to_real(a) + bits_to_real(b));
    endfunction

    function automatic logic [31:0] f32_sub(logic [31:0] a, logic [31:0] b);
        return real_to_bits(bits_to_real(a) - bits_to_real(b));
    endfunction

    function automatic logic [31:0] predict_exp(logic [31:0] x);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] y;
        logic [31:0] fx;
        logic [31:0] tr;
        logic [31:0] z;
        logic [31:0] p;
        logic [31:0] scale;
        logic [31:0] coef[6];
        logic [8:0]  e;
        int          n;
        hi      = real_to_bits(88.3762626647949);
        lo      = {1'b1, hi[30:0]};
        coef[0] = real_to_bits(1.9875691500E-4);
        coef[1] = real_to_bits(1.3981999507E-3);
        coef[2] = real_to_bits(8.3334519073E-3);
        coef[3] = real_to_bits(4.1665795894E-2);
        coef[4] = real_to_bits(1.6666665459E-1);
        coef[5] = real_to_bits(5.0000001201E-1);
        y = x;
        if ((x[30:23] == 8'hff && x[22:0] != 0) || !(bits_to_real(x) < bits_to_real(hi)))
            y = hi;
        if (!(bits_to_real(y) > bits_to_real(lo))) y = lo;
        fx = f32_add(f32_mul(y, real_to_bits(1.44269504088896341)), real_to_bits(0.5));
        n  = $rtoi(bits_to_real(fx));
        tr = real_to_bits(real'(n));
        if (bits_to_real(tr) > bits_to_real(fx)) tr = f32_sub(tr, real_to_bits(1.0));
        n  = $rtoi(bits_to_real(tr));
        y  = f32_sub(y, f32_mul(tr, real_to_bits(0.693359375 - 2.12194440e-4)));
        z  = f32_mul(y, y);
        p  = coef[0];
        for (int i = 1; i < 6; i++) p = f32_add(f32_mul(p, y), coef[i]);
        p  = f32_mul(p, z);
        p  = f32_add(p, y);
        p  = f32_add(p, real_to_bits(1.0));
        e  = 9'(n + 127);
        scale = {e, 23'h0};
        return f32_mul(p, scale);
    endfunction

    // hold the request until the handshake, then record the expectation
    task automatic send_request(logic [31:0] x, bit known, logic [31:0] result);
        s_valid  <= 1'b1;
        s_x_bits <= x;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
            @(posedge aclk);
        end
        @(posedge aclk);
        exp_queue.push_back(known ? result : predict_exp(x));
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] random_arg();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return {1'($urandom), 8'($urandom_range(133, 100)), 23'($urandom)};
        if (pick < 70) return {1'($urandom), 8'h85, 7'b0110000, 16'($urandom)};
        return 32'($urandom);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 400;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_queue.size() == 0) begin
                $error("result_bits: unexpected result %h", m_result_bits);
                fail_count++;
            end else begin
                if (m_result_bits !== exp_queue[0]) begin
                    $error("result_bits: expected %h, actual %h", exp_queue[0], m_result_bits);
                    fail_count++;
                end
                void'(exp_queue.pop_front());
            end
        end
    end

    initial begin
        dir_row_t rows[$];
        rows = '{
            '{32'h00000000, 1'b1, 32'h3F800000}, '{32'h80000000, 1'b1, 32'h3F800000},
            '{32'h7F800000, 1'b0, 32'h0}, '{32'hFF800000, 1'b0, 32'h0},
            '{32'h7FC00000, 1'b0, 32'h0}, '{32'hFFC00000, 1'b0, 32'h0},
            '{32'h7F800001, 1'b0, 32'h0}, '{32'hFFFFFFFF, 1'b0, 32'h0},
            '{32'h00000001, 1'b0, 32'h0}, '{32'h80000001, 1'b0, 32'h0},
            '{32'h007FFFFF, 1'b0, 32'h0}, '{32'h7F7FFFFF, 1'b0, 32'h0},
            '{32'hFF7FFFFF, 1'b0, 32'h0}, '{32'h42B0C0A5, 1'b0, 32'h0},
            '{32'hC2B0C0A5, 1'b0, 32'h0}, '{32'h42B0C0A6, 1'b0, 32'h0},
            '{32'hC2B0C0A6, 1'b0, 32'h0}, '{32'h42B00000, 1'b0, 32'h0},
            '{32'hC2AE0000, 1'b0, 32'h0}, '{32'hC2AFFFFF, 1'b0, 32'h0},
            '{32'h3F800000, 1'b0, 32'h0}, '{32'hBF800000, 1'b0, 32'h0},
            '{32'h3F317218, 1'b0, 32'h0}, '{32'h3F000000, 1'b0, 32'h0}
        };
        fail_count    = 0;
        send_idle_pct = 25;
        recv_idle_pct = 78;
        hold_req      = 1'b0;
        hold_cnt      = 0;
        stim_done     = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_x_bits      = 32'h0;
        m_ready       = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) send_request(rows[i].x, rows[i].known, rows[i].result);
        repeat (550) send_request(random_arg(), 1'b0, 32'h0);
        send_idle_pct = 78;
        recv_idle_pct = 25;
        repeat (550) send_request(random_arg(), 1'b0, 32'h0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (550) send_request(random_arg(), 1'b0, 32'h0);
        s_valid <= 1'b0;
        while (exp_queue.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
